>>> rtl/ffrc_pkg.sv
// Shared types, constants and the CRC-16 step for the fixed frame response checker.
// No dependencies; compile first.
package ffrc_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_FUNCTION = 1'b1;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] DEVICE_ADDRESS_RESET    = 8'hAA;
  localparam logic [7:0] EXPECTED_FUNCTION_RESET = 8'h01;

  // Modbus CRC-16, reflected
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Exception responses carry the function code with bit 7 set
  localparam logic [7:0] EXCEPTION_BIT = 8'h80;

  // Frame byte positions
  localparam logic [2:0] POS_HUNT       = 3'd0;
  localparam logic [2:0] POS_FUNCTION   = 3'd1;
  localparam logic [2:0] POS_FIRST_HI   = 3'd2;
  localparam logic [2:0] POS_FIRST_LO   = 3'd3;
  localparam logic [2:0] POS_SECOND_HI  = 3'd4;
  localparam logic [2:0] POS_SECOND_LO  = 3'd5;
  localparam logic [2:0] POS_CRC_LOW    = 3'd6;
  localparam logic [2:0] POS_CRC_HIGH   = 3'd7;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_BAD_FUNCTION = 2'd1,
    STATUS_BAD_CRC      = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] device_address;
    logic [7:0] expected_function;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic        device_exception;
    logic [7:0]  function_code;
    logic [15:0] first_word;
    logic [15:0] second_word;
  } result_t;

  // Fold one byte into the CRC, LSB first
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

>>> rtl/ffrc_if.sv
// Valid/ready channel interfaces for received bytes and frame results.
// Depends on ffrc_pkg.
interface ffrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ffrc_result_if import ffrc_pkg::*; ();
  logic        valid;
  logic        ready;
  status_t     status;
  logic        device_exception;
  logic [7:0]  function_code;
  logic [15:0] first_word;
  logic [15:0] second_word;

  modport source (output valid, output status, output device_exception,
                  output function_code, output first_word, output second_word,
                  input ready);
  modport sink   (input valid, input status, input device_exception,
                  input function_code, input first_word, input second_word,
                  output ready);
endinterface

>>> rtl/fixed_frame_response_checker.sv
// Top level of the fixed frame response checker: configuration registers, frame stage and
// result register. Depends on ffrc_pkg, ffrc_if, ffrc_frame, ffrc_out.
// Throughput: one byte per cycle, set by the unrolled CRC-16 byte step; a final CRC byte waits
// in the input register while an earlier result is still untaken, which holds off new bytes.
// The final CRC byte passes the input register, its result the result register. Reset (rst high,
// synchronous): hunting, CRC 0xFFFF, device_address 0xAA, expected_function 0x01, empty.
module fixed_frame_response_checker import ffrc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ffrc_byte_if.sink              rx,
  ffrc_result_if.source          res
);

  cfg_t    cfg;
  logic    res_ready;
  logic    res_load;
  result_t res_data;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address    <= DEVICE_ADDRESS_RESET;
      cfg.expected_function <= EXPECTED_FUNCTION_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEVICE_ADDRESS:    cfg.device_address    <= cfg_data;
        REG_EXPECTED_FUNCTION: cfg.expected_function <= cfg_data;
        default: ;
      endcase
    end
  end

  ffrc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rx        (rx),
    .res_ready (res_ready),
    .res_load  (res_load),
    .res       (res_data)
  );

  ffrc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res       (res_data),
    .res_ready (res_ready),
    .out       (res)
  );

endmodule

>>> rtl/ffrc_frame.sv
// Input register, frame sequencing, CRC accumulation and result evaluation.
// Depends on ffrc_pkg and ffrc_byte_if.
module ffrc_frame import ffrc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  ffrc_byte_if.sink    rx,
  input  logic         res_ready,
  output logic         res_load,
  output result_t      res
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic [2:0]  byte_position;
  logic [15:0] running_crc;
  logic [7:0]  held_function;
  logic [15:0] held_first_word;
  logic [15:0] held_second_word;
  logic [7:0]  held_crc_low;

  logic        stall;
  logic        advance;
  logic [15:0] crc_next;
  logic [15:0] crc_got;
  logic [7:0]  exc_code;
  logic        fn_ok;

  // Hold the byte at frame end while the result register is still occupied
  assign stall    = in_valid && (byte_position == POS_CRC_HIGH) && !res_ready;
  assign advance  = in_valid && !stall;
  assign rx.ready = !in_valid || !stall;

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  // Restart the CRC on the address byte
  assign crc_next = crc16_update((byte_position == POS_HUNT) ? CRC_INIT : running_crc,
                                 in_byte);

  // Advance the frame position and CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_HUNT;
      running_crc   <= CRC_INIT;
    end else if (advance) begin
      case (byte_position)
        POS_HUNT: begin
          if (in_byte == cfg.device_address) begin
            running_crc   <= crc_next;
            byte_position <= POS_FUNCTION;
          end
        end
        POS_CRC_LOW: begin
          byte_position <= POS_CRC_HIGH;
        end
        POS_CRC_HIGH: begin
          running_crc   <= CRC_INIT;
          byte_position <= POS_HUNT;
        end
        default: begin
          running_crc   <= crc_next;
          byte_position <= byte_position + 3'd1;
        end
      endcase
    end
  end

  // Collect frame payload bytes
  always_ff @(posedge clk) begin
    if (advance) begin
      case (byte_position)
        POS_FUNCTION:  held_function           <= in_byte;
        POS_FIRST_HI:  held_first_word[15:8]   <= in_byte;
        POS_FIRST_LO:  held_first_word[7:0]    <= in_byte;
        POS_SECOND_HI: held_second_word[15:8]  <= in_byte;
        POS_SECOND_LO: held_second_word[7:0]   <= in_byte;
        POS_CRC_LOW:   held_crc_low            <= in_byte;
        default: ;
      endcase
    end
  end

  // Evaluate the finished frame; function fault outranks CRC fault
  assign crc_got  = {in_byte, held_crc_low};
  assign exc_code = cfg.expected_function | EXCEPTION_BIT;
  assign fn_ok    = (held_function == cfg.expected_function) ||
                    (held_function == exc_code);

  always_comb begin
    res.device_exception = (held_function == exc_code);
    res.function_code    = held_function;
    res.first_word       = held_first_word;
    res.second_word      = held_second_word;
    if (!fn_ok) begin
      res.status = STATUS_BAD_FUNCTION;
    end else if (crc_got != running_crc) begin
      res.status = STATUS_BAD_CRC;
    end else begin
      res.status = STATUS_OK;
    end
  end

  assign res_load = advance && (byte_position == POS_CRC_HIGH);

  // Frame end always returns to hunting
  a_frame_end_hunts: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (byte_position == POS_HUNT))
    else $error("frame end did not return to hunting");

  // A non-address byte while hunting keeps hunting
  a_hunt_holds: assert property (@(posedge clk) disable iff (rst)
    advance && (byte_position == POS_HUNT) && (in_byte != cfg.device_address)
    |=> (byte_position == POS_HUNT))
    else $error("left hunting without an address match");

  // A result is never produced into a busy result register
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_load |-> res_ready)
    else $error("result loaded while result register busy");

endmodule

>>> rtl/ffrc_out.sv
// Result register driving the output channel.
// Depends on ffrc_pkg and ffrc_result_if.
module ffrc_out import ffrc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  result_t        res,
  output logic           res_ready,
  ffrc_result_if.source  out
);

  logic    out_valid;
  result_t held;

  assign res_ready = !out_valid || out.ready;

  // Hold a result until its transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign out.valid            = out_valid;
  assign out.status           = held.status;
  assign out.device_exception = held.device_exception;
  assign out.function_code    = held.function_code;
  assign out.first_word       = held.first_word;
  assign out.second_word      = held.second_word;

  // A waiting result must not be replaced
  a_hold_waiting: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out.ready |-> !load)
    else $error("waiting result overwritten");

endmodule
